/* rtl/msms_pkg.sv */
// Shared types and constants for the multiway sorted merge sweep.
// Used by msms_ctrl, msms_dpath and multiway_sorted_merge_sweep_top.
package msms_pkg;

  localparam int DIM_W   = 3;   // list number on the ports
  localparam int POS_W   = 8;   // element index on the ports
  localparam int LEN_W   = 9;   // list length, up to 256
  localparam int VAL_W   = 32;  // port value width, Q16.16
  localparam int COUNT_W = 4;   // list_count register

  // Item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic             load;     // store one element, rewind cursors
    logic             start;    // latch tuple size and done flag, clear best
    logic             issue;    // read current and next value of list idx
    logic             advance;  // move the winning cursor
    logic [DIM_W-1:0] idx;      // list being read
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             issue_ok;  // read stage free for a new list
    logic             drained;   // read stage empty, best pick final
    logic [DIM_W-1:0] last_idx;  // last list of the current tuple
  } dp_sts_t;

endpackage

/* rtl/multiway_sorted_merge_sweep_top.sv */
// Top level of the multiway sorted merge sweep.
// Depends on msms_pkg, msms_ctrl and msms_dpath.
//
//   channel  handshake               payload
//   in       in_valid_i/in_stall_o   func, list_id, position, value, list_end
//   out      out_valid_o/out_stall_i dim, cursor, element, tuple_last, sweep_done
//   cfg      cfg_we_i                cfg_wdata_i (list_count)
//
// A load beat is taken whenever the block is idle. A step beat walks the n
// lists in use before the next beat is taken: the beat is taken, then one
// list is read per cycle through the two read ports of the value memory,
// then the last read and its pick pass the read stage, then the cursor advances.
// A stall on the output holds the list reads; the last result may still
// wait in the output register while the next beat is taken.
// Reset clears lengths and cursors and sets list_count to 1; the value
// memory is not cleared.
module multiway_sorted_merge_sweep_top import msms_pkg::*; #(
  parameter int LISTS      = 8,
  parameter int DEPTH      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [COUNT_W-1:0]      cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_func_i,
  input  logic [DIM_W-1:0]        in_list_id_i,
  input  logic [POS_W-1:0]        in_position_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  logic                    in_list_end_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DIM_W-1:0]        out_dim_o,
  output logic [POS_W-1:0]        out_cursor_o,
  output logic signed [VAL_W-1:0] out_element_o,
  output logic                    out_tuple_last_o,
  output logic                    out_sweep_done_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  msms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  msms_dpath #(
    .LISTS      (LISTS),
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_list_id_i     (in_list_id_i),
    .in_position_i    (in_position_i),
    .in_value_i       (in_value_i),
    .in_list_end_i    (in_list_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_dim_o        (out_dim_o),
    .out_cursor_o     (out_cursor_o),
    .out_element_o    (out_element_o),
    .out_tuple_last_o (out_tuple_last_o),
    .out_sweep_done_o (out_sweep_done_o)
  );

endmodule

/* rtl/msms_ctrl.sv */
// Sequencer for the merge sweep: takes items, walks the lists of a tuple.
// Depends on msms_pkg for the command and status structs.
module msms_ctrl import msms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_func_i,
  output logic      in_stall_o,
  output ctrl_cmd_t cmd_o,
  input  dp_sts_t   sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e           state_q, state_d;
  logic [DIM_W-1:0] idx_q, idx_d;

  // Take items only between steps
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == FUNC_STEP) begin
            cmd_o.start = 1'b1;
            idx_d       = '0;
            state_d     = ST_RUN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (sts_i.issue_ok) begin
          cmd_o.issue = 1'b1;
          if (idx_q == sts_i.last_idx) begin
            state_d = ST_DRAIN;
          end else begin
            idx_d = idx_q + DIM_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.drained) begin
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and list counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* rtl/msms_dpath.sv */
// Datapath of the merge sweep: value memory, lengths, cursors, read stage,
// minimum pick and output register. Depends on msms_pkg.
module msms_dpath import msms_pkg::*; #(
  parameter int LISTS      = 8,
  parameter int DEPTH      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_sts_t                 sts_o,
  input  logic                    cfg_we_i,
  input  logic [COUNT_W-1:0]      cfg_wdata_i,
  input  logic [DIM_W-1:0]        in_list_id_i,
  input  logic [POS_W-1:0]        in_position_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  logic                    in_list_end_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DIM_W-1:0]        out_dim_o,
  output logic [POS_W-1:0]        out_cursor_o,
  output logic signed [VAL_W-1:0] out_element_o,
  output logic                    out_tuple_last_o,
  output logic                    out_sweep_done_o
);

  localparam int IW        = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PB        = $clog2(DEPTH);
  localparam int PX        = (PB > LEN_W) ? PB : LEN_W;
  localparam int MEM_DEPTH = LISTS * (2 ** PB);
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Value memory, one row of 2**PB entries per list
  logic signed [VALUE_BITS-1:0] mem_q [MEM_DEPTH];
  logic signed [VALUE_BITS-1:0] rd_cur_q, rd_nxt_q;

  logic [LEN_W-1:0]   len_q [LISTS];
  logic [POS_W-1:0]   cur_q [LISTS];
  logic [COUNT_W-1:0] list_count_q;

  logic [DIM_W-1:0]   last_q, last_d;
  logic               done_q, done_d;

  // Read stage
  logic               s1_valid_q;
  logic [DIM_W-1:0]   s1_idx_q;
  logic [POS_W-1:0]   s1_cur_q;
  logic               s1_cand_q;
  logic               s1_move;

  // Running minimum over next values
  logic                         best_have_q;
  logic [IW-1:0]                best_idx_q;
  logic signed [VALUE_BITS-1:0] best_val_q;

  // Load side
  logic                         ld_ok;
  logic [IW-1:0]                ld_lid;
  logic [PX-1:0]                ld_pos_x;
  logic [AW-1:0]                ld_addr;
  logic signed [VALUE_BITS-1:0] ld_val;
  logic [LEN_W-1:0]             ld_len;

  // Issue side
  logic [IW-1:0]    is_idx;
  logic [POS_W-1:0] is_cur;
  logic [LEN_W-1:0] is_nxt;
  logic [LEN_W-1:0] is_len;
  logic             is_cand;
  logic [PX-1:0]    is_cur_x, is_nxt_x;
  logic [AW-1:0]    rd_cur_addr, rd_nxt_addr;

  // Tuple size from the register, clamped to 1..LISTS
  always_comb begin
    if (list_count_q == '0) begin
      last_d = '0;
    end else if (int'(list_count_q) > LISTS) begin
      last_d = DIM_W'(LISTS - 1);
    end else begin
      last_d = DIM_W'(list_count_q - COUNT_W'(1));
    end
  end

  // Sweep done when no list in use has a next element
  always_comb begin
    done_d = 1'b1;
    for (int i = 0; i < LISTS; i++) begin
      if ((DIM_W'(i) <= last_d) &&
          (({1'b0, cur_q[i]} + LEN_W'(1)) <
           ((len_q[i] == '0) ? LEN_W'(1) : len_q[i]))) begin
        done_d = 1'b0;
      end
    end
  end

  // Load address and stored value
  assign ld_ok    = (int'(in_list_id_i) < LISTS) && (int'(in_position_i) < DEPTH);
  assign ld_lid   = in_list_id_i[IW-1:0];
  assign ld_pos_x = PX'(in_position_i);
  assign ld_addr  = AW'({ld_lid, ld_pos_x[PB-1:0]});
  assign ld_val   = VALUE_BITS'(in_value_i);
  assign ld_len   = {1'b0, in_position_i} + LEN_W'(1);

  // Issue addresses for current and next element
  assign is_idx      = cmd_i.idx[IW-1:0];
  assign is_cur      = cur_q[is_idx];
  assign is_len      = len_q[is_idx];
  assign is_nxt      = {1'b0, is_cur} + LEN_W'(1);
  assign is_cand     = is_nxt < ((is_len == '0) ? LEN_W'(1) : is_len);
  assign is_cur_x    = PX'(is_cur);
  assign is_nxt_x    = PX'(is_nxt);
  assign rd_cur_addr = AW'({is_idx, is_cur_x[PB-1:0]});
  assign rd_nxt_addr = AW'({is_idx, is_nxt_x[PB-1:0]});

  // Memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ld_ok) begin
      mem_q[ld_addr] <= ld_val;
    end
    if (cmd_i.issue) begin
      rd_cur_q <= mem_q[rd_cur_addr];
      rd_nxt_q <= mem_q[rd_nxt_addr];
    end
  end

  // Move a read beat into the output register when it is free
  assign s1_move = s1_valid_q && (!out_valid_o || !out_stall_i);

  assign sts_o.issue_ok = !s1_valid_q || s1_move;
  assign sts_o.drained  = !s1_valid_q;
  assign sts_o.last_idx = last_q;

  // Configuration, lengths and cursors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count_q <= COUNT_W'(1);
      for (int i = 0; i < LISTS; i++) begin
        len_q[i] <= '0;
        cur_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        list_count_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        for (int i = 0; i < LISTS; i++) begin
          cur_q[i] <= '0;
        end
        if (ld_ok && in_list_end_i) begin
          len_q[ld_lid] <= ld_len;
        end
      end
      if (cmd_i.advance && !done_q && best_have_q) begin
        cur_q[best_idx_q] <= cur_q[best_idx_q] + POS_W'(1);
      end
    end
  end

  // Tuple bookkeeping and read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      done_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      best_have_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        last_q      <= last_d;
        done_q      <= done_d;
        best_have_q <= 1'b0;
      end else if (s1_move && s1_cand_q &&
                   (!best_have_q || (rd_nxt_q < best_val_q))) begin
        best_have_q <= 1'b1;
      end
      if (cmd_i.issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Read stage payload, best pick and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_idx_q  <= cmd_i.idx;
      s1_cur_q  <= is_cur;
      s1_cand_q <= is_cand;
    end
    if (s1_move && s1_cand_q && (!best_have_q || (rd_nxt_q < best_val_q))) begin
      best_idx_q <= s1_idx_q[IW-1:0];
      best_val_q <= rd_nxt_q;
    end
    if (s1_move) begin
      out_dim_o        <= s1_idx_q;
      out_cursor_o     <= s1_cur_q;
      out_element_o    <= VAL_W'(rd_cur_q);
      out_tuple_last_o <= (s1_idx_q == last_q);
      out_sweep_done_o <= done_q;
    end
  end

endmodule

/* bench/msms_merge_checker.sv */
`timescale 1ns / 100ps
// Checker for the multiway sorted merge sweep: watches the config, input and
// output channels, predicts each tuple and compares every result beat.
// Depends on msms_pkg.
module msms_merge_checker import msms_pkg::*; #(
  parameter int LISTS = 8,
  parameter int DEPTH = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [COUNT_W-1:0]      cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    in_func_i,
  input  logic [DIM_W-1:0]        in_list_id_i,
  input  logic [POS_W-1:0]        in_position_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  input  logic                    in_list_end_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [DIM_W-1:0]        out_dim_i,
  input  logic [POS_W-1:0]        out_cursor_i,
  input  logic signed [VAL_W-1:0] out_element_i,
  input  logic                    out_tuple_last_i,
  input  logic                    out_sweep_done_i,
  output int                      pending_o,
  output int                      errors_o,
  output int                      checked_o
);

  typedef struct packed {
    logic [DIM_W-1:0]        dim;
    logic [POS_W-1:0]        cursor;
    logic signed [VAL_W-1:0] element;
    logic                    tuple_last;
    logic                    sweep_done;
  } merge_result_t;

  // Shadow of the block: element store, lengths, cursors, list_count
  logic signed [VAL_W-1:0] elem_mem [LISTS][DEPTH];
  int                      len_tab [LISTS];
  int                      cursor_tab [LISTS];
  int                      count_reg;
  merge_result_t           merge_out_q [$];
  int                      err_cnt = 0;
  int                      seen_cnt = 0;

  // A list with no terminating element still spans one entry
  function automatic int list_span(input int l);
    return (len_tab[l] == 0) ? 1 : len_tab[l];
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t merge check: %s", $time, msg);
  endtask

  // Store one element and rewind every cursor
  task automatic record_load();
    int i;
    if (in_list_id_i < LISTS && in_position_i < DEPTH) begin
      elem_mem[in_list_id_i][in_position_i] = in_value_i;
      if (in_list_end_i) len_tab[in_list_id_i] = in_position_i + 1;
    end
    for (i = 0; i < LISTS; i++) cursor_tab[i] = 0;
  endtask

  // Queue the current tuple, then advance the list with the smallest next value
  task automatic predict_tuple();
    int                      n;
    int                      i;
    int                      best;
    bit                      done;
    bit                      have;
    logic signed [VAL_W-1:0] best_val;
    logic signed [VAL_W-1:0] cand;
    merge_result_t           r;
    n = (count_reg == 0) ? 1 : ((count_reg > LISTS) ? LISTS : count_reg);
    done = 1'b1;
    for (i = 0; i < n; i++)
      if (cursor_tab[i] + 1 < list_span(i)) done = 1'b0;
    for (i = 0; i < n; i++) begin
      r.dim        = DIM_W'(i);
      r.cursor     = POS_W'(cursor_tab[i]);
      r.element    = elem_mem[i][cursor_tab[i]];
      r.tuple_last = (i == n - 1);
      r.sweep_done = done;
      merge_out_q.insert(merge_out_q.size(), r);
    end
    if (!done) begin
      have = 1'b0;
      best = 0;
      best_val = '0;
      for (i = 0; i < n; i++) begin
        if (cursor_tab[i] + 1 < list_span(i)) begin
          cand = elem_mem[i][cursor_tab[i] + 1];
          // strict compare keeps the lowest list on ties
          if (!have || cand < best_val) begin
            have = 1'b1;
            best = i;
            best_val = cand;
          end
        end
      end
      cursor_tab[best] = (cursor_tab[best] + 1) % 256;
    end
  endtask

  // Compare one output beat against the oldest queued result
  task automatic check_result();
    merge_result_t want;
    if (merge_out_q.size() == 0) begin
      report_mismatch($sformatf("result beat dim %0d with no tuple pending", out_dim_i));
    end else begin
      want = merge_out_q.pop_front();
      seen_cnt++;
      if (out_dim_i !== want.dim)
        report_mismatch($sformatf("dim got %0d expected %0d", out_dim_i, want.dim));
      if (out_cursor_i !== want.cursor)
        report_mismatch($sformatf("dim %0d cursor got %0d expected %0d",
                                  want.dim, out_cursor_i, want.cursor));
      if (out_element_i !== want.element)
        report_mismatch($sformatf("dim %0d element got %h expected %h",
                                  want.dim, out_element_i, want.element));
      if (out_tuple_last_i !== want.tuple_last)
        report_mismatch($sformatf("dim %0d tuple_last got %b expected %b",
                                  want.dim, out_tuple_last_i, want.tuple_last));
      if (out_sweep_done_i !== want.sweep_done)
        report_mismatch($sformatf("dim %0d sweep_done got %b expected %b",
                                  want.dim, out_sweep_done_i, want.sweep_done));
    end
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LISTS; i++) begin
        len_tab[i] = 0;
        cursor_tab[i] = 0;
      end
      count_reg = 1;
      merge_out_q.delete();
      pending_o <= 0;
      errors_o  <= err_cnt;
      checked_o <= seen_cnt;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_func_i == FUNC_LOAD) record_load();
        else predict_tuple();
      end
      pending_o <= merge_out_q.size();
      errors_o  <= err_cnt;
      checked_o <= seen_cnt;
    end
  end

endmodule

/* bench/tb_multiway_sorted_merge_sweep_top.sv */
`timescale 1ns / 100ps
// Testbench top for the multiway sorted merge sweep: drives loads, steps and
// list_count writes with random idling and gives the verdict.
// Depends on msms_pkg, multiway_sorted_merge_sweep_top and msms_merge_checker.
module tb_multiway_sorted_merge_sweep_top;
  import msms_pkg::*;

  localparam int LISTS          = 8;
  localparam int DEPTH          = 256;
  localparam int TARGET_BEATS   = 410;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [COUNT_W-1:0]      cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    in_func_i;
  logic [DIM_W-1:0]        in_list_id_i;
  logic [POS_W-1:0]        in_position_i;
  logic signed [VAL_W-1:0] in_value_i;
  logic                    in_list_end_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [DIM_W-1:0]        out_dim_o;
  logic [POS_W-1:0]        out_cursor_o;
  logic signed [VAL_W-1:0] out_element_o;
  logic                    out_tuple_last_o;
  logic                    out_sweep_done_o;

  int pending;
  int errors;
  int checked;
  int beats = 0;
  int loads = 0;
  int steps = 0;
  int cfg_writes = 0;
  int holds = 0;
  int gap_pct = 16;
  int stall_pct = 54;
  int hold_reqs = 0;
  int holds_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // Stimulus bookkeeping: which entries hold data, and each list's length
  bit written [LISTS][DEPTH];
  int len_shadow [LISTS];

  multiway_sorted_merge_sweep_top #(
    .LISTS(LISTS), .DEPTH(DEPTH), .VALUE_BITS(32)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_func_i(in_func_i), .in_list_id_i(in_list_id_i),
    .in_position_i(in_position_i), .in_value_i(in_value_i),
    .in_list_end_i(in_list_end_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_dim_o(out_dim_o), .out_cursor_o(out_cursor_o),
    .out_element_o(out_element_o), .out_tuple_last_o(out_tuple_last_o),
    .out_sweep_done_o(out_sweep_done_o)
  );

  msms_merge_checker #(.LISTS(LISTS), .DEPTH(DEPTH)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o),
    .in_func_i(in_func_i), .in_list_id_i(in_list_id_i),
    .in_position_i(in_position_i), .in_value_i(in_value_i),
    .in_list_end_i(in_list_end_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i),
    .out_dim_i(out_dim_o), .out_cursor_i(out_cursor_o),
    .out_element_i(out_element_o), .out_tuple_last_i(out_tuple_last_o),
    .out_sweep_done_i(out_sweep_done_o),
    .pending_o(pending), .errors_o(errors), .checked_o(checked)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when the sender asks for one
  always @(posedge clk_i) begin
    if (hold_reqs != holds_served) begin
      holds_served <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      out_stall_i  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input logic func, input int id, input int pos,
                           input logic [VAL_W-1:0] val, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_func_i     <= func;
    in_list_id_i  <= DIM_W'(id);
    in_position_i <= POS_W'(pos);
    in_value_i    <= val;
    in_list_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    beats++;
    if (func == FUNC_LOAD) loads++;
    else steps++;
    // swap the idling sides after a third, drop idling after two thirds
    if (beats >= 2 * TARGET_BEATS / 3) begin
      gap_pct = 0;
      stall_pct <= 0;
    end else if (beats >= TARGET_BEATS / 3) begin
      gap_pct = 54;
      stall_pct <= 16;
    end
  endtask

  task automatic load_elem(input int id, input int pos, input logic [VAL_W-1:0] val,
                           input logic last);
    send_beat(FUNC_LOAD, id, pos, val, last);
    written[id][pos] = 1'b1;
    if (last) len_shadow[id] = pos + 1;
  endtask

  // Step with random don't-care fields; request a long output hold twice
  task automatic step_sweep();
    if ((holds == 0 && beats >= 60) || (holds == 1 && beats >= 330)) begin
      hold_reqs <= hold_reqs + 1;
      holds++;
    end
    send_beat(FUNC_STEP, $urandom_range(LISTS - 1), $urandom_range(DEPTH - 1),
              $urandom(), 1'($urandom_range(1)));
  endtask

  // Drain, let the block settle, then write list_count
  task automatic set_list_count(input logic [COUNT_W-1:0] cnt);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  function automatic bit prefix_written(input int id, input int pos);
    int i;
    for (i = 0; i <= pos; i++)
      if (!written[id][i]) return 1'b0;
    return 1'b1;
  endfunction

  // Load a whole list: mostly sorted, sometimes with many ties, sometimes not sorted
  task automatic load_list(input int id);
    int         len;
    int         mode;
    int         i;
    longint     acc;
    logic [31:0] vals [16];
    len  = ($urandom_range(11) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    mode = $urandom_range(9);
    acc  = longint'($signed($urandom()));
    for (i = 0; i < len; i++) begin
      if (mode == 9) acc = longint'($signed($urandom()));
      else if (mode < 3) acc = acc + $urandom_range(1);
      else acc = acc + $urandom_range(1 << 27);
      if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
      vals[i] = acc[31:0];
    end
    if ($urandom_range(3) == 0) begin
      for (i = len - 1; i >= 0; i--) load_elem(id, i, vals[i], i == len - 1);
    end else begin
      for (i = 0; i < len; i++) load_elem(id, i, vals[i], i == len - 1);
    end
  endtask

  // Stray load; terminate only where every lower entry already holds data
  task automatic noise_load();
    int   id;
    int   pos;
    logic last;
    id   = $urandom_range(LISTS - 1);
    pos  = ($urandom_range(3) == 0) ? $urandom_range(DEPTH - 1) : $urandom_range(7);
    last = $urandom_range(1) && prefix_written(id, pos);
    load_elem(id, pos, $urandom(), last);
  endtask

  task automatic run_directed();
    int i;
    // lone unterminated element: done at once, then the same tuple again
    load_elem(0, 0, 32'h8000_0000, 1'b0);
    repeat (2) step_sweep();
    load_elem(0, 1, 32'h7FFF_FFFF, 1'b1);
    repeat (3) step_sweep();
    load_elem(0, DEPTH - 1, 32'h5A5A_A5A5, 1'b0);
    // lists 1 and 2 tie on their second element
    load_elem(1, 0, 32'h0001_0000, 1'b0);
    load_elem(1, 1, 32'h0001_0000, 1'b1);
    load_elem(2, 0, 32'hFFFF_FFFF, 1'b0);
    load_elem(2, 1, 32'h0001_0000, 1'b1);
    for (i = 3; i < LISTS; i++) load_elem(i, 0, $urandom(), 1'b1);
    // count above the list total clamps, zero counts as one
    set_list_count(4'd15);
    repeat (5) step_sweep();
    set_list_count(4'd0);
    step_sweep();
  endtask

  // One sweep: pick a count, reload some lists, step through and a bit past the end
  task automatic run_sweep();
    int raw;
    int n;
    int total;
    int i;
    case ($urandom_range(9))
      0:       raw = 0;
      1:       raw = $urandom_range(9, 15);
      2:       raw = LISTS;
      3:       raw = 1;
      default: raw = $urandom_range(1, LISTS);
    endcase
    set_list_count(COUNT_W'(raw));
    n = (raw == 0) ? 1 : ((raw > LISTS) ? LISTS : raw);
    for (i = 0; i < n; i++)
      if ($urandom_range(4) != 0) load_list(i);
    total = 1 + $urandom_range(2);
    for (i = 0; i < n; i++)
      total += ((len_shadow[i] == 0) ? 1 : len_shadow[i]) - 1;
    for (i = 0; i < total; i++) begin
      if ($urandom_range(19) == 0) noise_load();
      step_sweep();
    end
  endtask

  initial begin
    for (int l = 0; l < LISTS; l++) len_shadow[l] = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    in_func_i     <= FUNC_LOAD;
    in_list_id_i  <= '0;
    in_position_i <= '0;
    in_value_i    <= '0;
    in_list_end_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    while (beats < TARGET_BEATS) run_sweep();

    // drain every queued result, then let the block go quiet
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d beats (%0d loads, %0d steps), %0d result beats compared.",
             beats, loads, steps, checked);
    $display("list_count written %0d times including 0 and 15; %0d long output hold-offs.",
             cfg_writes, holds);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
